// ----- rtl/thc_pkg.sv -----
// Shared types and constants for the temperature and humidity compensation core.
// Used by every module of the block and by its checker; depends on nothing else.
package thc_pkg;

    // Pipeline split: temperature stages, then humidity stages.
    localparam int TEMP_STAGES = 4;
    localparam int HUM_STAGES  = 9;
    localparam int PIPE_DEPTH  = TEMP_STAGES + HUM_STAGES;

    // Configuration register indexes.
    localparam logic [2:0] REG_CAL_T1    = 3'd0;
    localparam logic [2:0] REG_CAL_T2    = 3'd1;
    localparam logic [2:0] REG_CAL_T3    = 3'd2;
    localparam logic [2:0] REG_CAL_H1    = 3'd3;
    localparam logic [2:0] REG_CAL_H2    = 3'd4;
    localparam logic [2:0] REG_CAL_H3    = 3'd5;
    localparam logic [2:0] REG_CAL_H4_H5 = 3'd6;
    localparam logic [2:0] REG_CAL_H6    = 3'd7;

    // Compensation constants.
    localparam logic [31:0] TEMP_ROUND   = 32'd128;
    localparam logic [31:0] HUM_OFFSET_T = 32'd76800;
    localparam logic [31:0] HUM_ROUND_A  = 32'd16384;
    localparam logic [31:0] HUM_BIAS_B   = 32'd32768;
    localparam logic [31:0] HUM_BIAS_C   = 32'd2097152;
    localparam logic [31:0] HUM_ROUND_D  = 32'd8192;
    localparam logic [31:0] HUM_MAX      = 32'd419430400;
    localparam logic [16:0] HUM_Q10_MAX  = 17'd102400;

    // Calibration register set as seen by the datapath.
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [23:0] h4_h5;
        logic [7:0]  h6;
    } t_cal;

endpackage

// ----- rtl/thc_pipe_ctrl.sv -----
// Valid tracking and per-stage load enables for the compensation pipeline.
// Depends on thc_pkg for the pipeline depth.
module thc_pipe_ctrl import thc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_stall,
    output logic [PIPE_DEPTH-1:0] o_en,
    output logic                  o_valid,
    output logic                  o_stall
);

    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;

    // A stage may load unless it and every stage after it is full and the sink stalls.
    for (genvar k = 0; k < PIPE_DEPTH; k++) begin : g_en
        assign o_en[k] = !i_stall || !(&r_vld[PIPE_DEPTH-1:k]);
    end

    // Valid bits advance with the data.
    always_comb begin
        n_vld = r_vld;
        if (o_en[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            if (o_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid = r_vld[PIPE_DEPTH-1];
    assign o_stall = !o_en[0];

endmodule

// ----- rtl/thc_temp_path.sv -----
// Temperature half of the datapath: fine temperature and hundredths of a degree.
// Depends on thc_pkg for constants and the calibration struct.
module thc_temp_path import thc_pkg::*; (
    input  logic                   i_clk,
    input  logic [TEMP_STAGES-1:0] i_en,
    input  t_cal                   i_cal,
    input  logic [19:0]            i_raw_temp,
    input  logic [15:0]            i_raw_hum,
    output logic [31:0]            o_fine,
    output logic [26:0]            o_centi,
    output logic [31:0]            o_hum_v,
    output logic [15:0]            o_raw_hum
);

    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_t3;
    logic [31:0] w_diff;
    logic [31:0] w_c5;
    logic [31:0] w_centi;

    // Stage registers.
    logic [31:0] r_p1, r_dd;
    logic [15:0] r_hum1, r_hum2, r_hum3, r_hum4;
    logic [31:0] r_a2, r_b2;
    logic [31:0] r_fine3;
    logic [31:0] r_fine4, r_v4;
    logic [26:0] r_centi4;

    assign w_t1   = {16'b0, i_cal.t1};
    assign w_t2   = {{16{i_cal.t2[15]}}, i_cal.t2};
    assign w_t3   = {{16{i_cal.t3[15]}}, i_cal.t3};
    assign w_diff = {16'b0, i_raw_temp[19:4]} - w_t1;

    // Stage 1: linear and square products of the raw reading.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p1   <= ({15'b0, i_raw_temp[19:3]} - {15'b0, i_cal.t1, 1'b0}) * w_t2;
            r_dd   <= w_diff * w_diff;
            r_hum1 <= i_raw_hum;
        end
    end

    // Stage 2: scale the linear term and apply the quadratic gain.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_a2   <= 32'($signed(r_p1) >>> 11);
            r_b2   <= 32'($signed(r_dd) >>> 12) * w_t3;
            r_hum2 <= r_hum1;
        end
    end

    // Stage 3: fine temperature.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_fine3 <= r_a2 + 32'($signed(r_b2) >>> 14);
            r_hum3  <= r_hum2;
        end
    end

    // Stage 4: temperature in hundredths and the humidity temperature offset.
    assign w_c5    = r_fine3 + {r_fine3[29:0], 2'b0} + TEMP_ROUND;
    assign w_centi = 32'($signed(w_c5) >>> 8);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_fine4  <= r_fine3;
            r_centi4 <= w_centi[26:0];
            r_v4     <= r_fine3 - HUM_OFFSET_T;
            r_hum4   <= r_hum3;
        end
    end

    assign o_fine    = r_fine4;
    assign o_centi   = r_centi4;
    assign o_hum_v   = r_v4;
    assign o_raw_hum = r_hum4;

endmodule

// ----- rtl/thc_hum_path.sv -----
// Humidity half of the datapath: Q7.10 relative humidity with final clamp.
// Depends on thc_pkg for constants and the calibration struct.
module thc_hum_path import thc_pkg::*; (
    input  logic                  i_clk,
    input  logic [HUM_STAGES-1:0] i_en,
    input  t_cal                  i_cal,
    input  logic [31:0]           i_fine,
    input  logic [26:0]           i_centi,
    input  logic [31:0]           i_hum_v,
    input  logic [15:0]           i_raw_hum,
    output logic [31:0]           o_fine,
    output logic [26:0]           o_centi,
    output logic [16:0]           o_hum_q10
);

    logic [31:0] w_h1, w_h2, w_h3, w_h4s, w_h5, w_h6;
    logic [31:0] w_y;
    logic [31:0] w_acc;
    logic [31:0] w_clamp;

    // Fine and centi values ride alongside the humidity math.
    logic [31:0] r_fine [HUM_STAGES];
    logic [26:0] r_centi [HUM_STAGES];

    logic [15:0] r_hum5;
    logic [31:0] r_hv5, r_vh6_5, r_vh3_5;
    logic [31:0] r_x6, r_ya6, r_yb6;
    logic [31:0] r_x7, r_y7;
    logic [31:0] r_x8, r_y8;
    logic [31:0] r_x9, r_y9;
    logic [31:0] r_v10;
    logic [31:0] r_v11, r_sq11;
    logic [31:0] r_v12, r_s12;
    logic [16:0] r_hum13;

    assign w_h1  = {24'b0, i_cal.h1};
    assign w_h2  = {{16{i_cal.h2[15]}}, i_cal.h2};
    assign w_h3  = {24'b0, i_cal.h3};
    assign w_h4s = {i_cal.h4_h5[11:0], 20'b0};
    assign w_h5  = {{20{i_cal.h4_h5[23]}}, i_cal.h4_h5[23:12]};
    assign w_h6  = {{24{i_cal.h6[7]}}, i_cal.h6};

    // Side channel for the temperature results.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_fine[0]  <= i_fine;
            r_centi[0] <= i_centi;
        end
        for (int k = 1; k < HUM_STAGES; k++) begin
            if (i_en[k]) begin
                r_fine[k]  <= r_fine[k-1];
                r_centi[k] <= r_centi[k-1];
            end
        end
    end

    // Stage 5: temperature-dependent products.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_hum5  <= i_raw_hum;
            r_hv5   <= w_h5 * i_hum_v;
            r_vh6_5 <= i_hum_v * w_h6;
            r_vh3_5 <= i_hum_v * w_h3;
        end
    end

    // Stage 6: offset term and the two factors of the scale term.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_x6  <= 32'($signed({2'b0, r_hum5, 14'b0} - w_h4s - r_hv5 + HUM_ROUND_A)
                         >>> 15);
            r_ya6 <= 32'($signed(r_vh6_5) >>> 10);
            r_yb6 <= 32'($signed(r_vh3_5) >>> 11) + HUM_BIAS_B;
        end
    end

    // Stage 7: product of the scale factors.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_x7 <= r_x6;
            r_y7 <= r_ya6 * r_yb6;
        end
    end

    // Stage 8: rescale and bias.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_x8 <= r_x7;
            r_y8 <= 32'($signed(r_y7) >>> 10) + HUM_BIAS_C;
        end
    end

    // Stage 9: apply the humidity scale word.
    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_x9 <= r_x8;
            r_y9 <= r_y8 * w_h2 + HUM_ROUND_D;
        end
    end

    // Stage 10: uncorrected humidity accumulator.
    assign w_y = 32'($signed(r_y9) >>> 14);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_v10 <= r_x9 * w_y;
        end
    end

    // Stage 11: square of the scaled accumulator.
    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_v11  <= r_v10;
            r_sq11 <= 32'($signed(r_v10) >>> 15) * 32'($signed(r_v10) >>> 15);
        end
    end

    // Stage 12: quadratic correction product.
    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_v12 <= r_v11;
            r_s12 <= 32'($signed(r_sq11) >>> 7) * w_h1;
        end
    end

    // Stage 13: subtract the correction, clamp to the valid range and scale.
    assign w_acc = r_v12 - 32'($signed(r_s12) >>> 4);

    always_comb begin
        if (w_acc[31]) begin
            w_clamp = '0;
        end else if (w_acc > HUM_MAX) begin
            w_clamp = HUM_MAX;
        end else begin
            w_clamp = w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r_hum13 <= w_clamp[28:12];
        end
    end

    assign o_fine    = r_fine[HUM_STAGES-1];
    assign o_centi   = r_centi[HUM_STAGES-1];
    assign o_hum_q10 = r_hum13;

endmodule

// ----- rtl/temp_humidity_compensation_core.sv -----
// Temperature and humidity compensation core. One sample request (20-bit raw temperature,
// 16-bit raw humidity) enters per clock while o_stall is low, and its result request leaves
// from the final stage: four stages build the fine temperature and hundredths of a degree,
// nine more build humidity in Q7.10 percent, with at most one rank of 32-bit multipliers per
// stage setting the depth. Stalls hold each full stage in place while empty stages keep
// filling, so a waiting result does not block new samples until the whole pipeline is full.
// Calibration registers reset to zero and should be written only while the pipeline is empty.
module temp_humidity_compensation_core import thc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Calibration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data,
    // Sample input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_raw_temp,
    input  logic [15:0] i_raw_hum,
    // Result output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_fine_temp,
    output logic [26:0] o_temp_centi,
    output logic [16:0] o_hum_q10
);

    t_cal                  r_cal;
    logic [PIPE_DEPTH-1:0] w_en;
    logic [31:0]           w_fine;
    logic [26:0]           w_centi;
    logic [31:0]           w_hum_v;
    logic [15:0]           w_raw_hum;

    // Calibration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CAL_T1:    r_cal.t1    <= i_cfg_data[15:0];
                REG_CAL_T2:    r_cal.t2    <= i_cfg_data[15:0];
                REG_CAL_T3:    r_cal.t3    <= i_cfg_data[15:0];
                REG_CAL_H1:    r_cal.h1    <= i_cfg_data[7:0];
                REG_CAL_H2:    r_cal.h2    <= i_cfg_data[15:0];
                REG_CAL_H3:    r_cal.h3    <= i_cfg_data[7:0];
                REG_CAL_H4_H5: r_cal.h4_h5 <= i_cfg_data;
                REG_CAL_H6:    r_cal.h6    <= i_cfg_data[7:0];
                default:       r_cal       <= r_cal;
            endcase
        end
    end

    // Pipeline control.
    thc_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_en    (w_en),
        .o_valid (o_valid),
        .o_stall (o_stall)
    );

    // Temperature stages.
    thc_temp_path u_temp (
        .i_clk      (i_clk),
        .i_en       (w_en[TEMP_STAGES-1:0]),
        .i_cal      (r_cal),
        .i_raw_temp (i_raw_temp),
        .i_raw_hum  (i_raw_hum),
        .o_fine     (w_fine),
        .o_centi    (w_centi),
        .o_hum_v    (w_hum_v),
        .o_raw_hum  (w_raw_hum)
    );

    // Humidity stages.
    thc_hum_path u_hum (
        .i_clk     (i_clk),
        .i_en      (w_en[PIPE_DEPTH-1:TEMP_STAGES]),
        .i_cal     (r_cal),
        .i_fine    (w_fine),
        .i_centi   (w_centi),
        .i_hum_v   (w_hum_v),
        .i_raw_hum (w_raw_hum),
        .o_fine    (o_fine_temp),
        .o_centi   (o_temp_centi),
        .o_hum_q10 (o_hum_q10)
    );

endmodule

// ----- rtl/thc_checker.sv -----
// Port-level checks for the temperature and humidity compensation core, bound to its top.
// Depends on thc_pkg for the humidity limit and on the top level's port list.
module thc_checker import thc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_fine_temp,
    input logic [26:0] o_temp_centi,
    input logic [16:0] o_hum_q10
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_fine_temp) && $stable(o_temp_centi)
                               && $stable(o_hum_q10))
        else $error("result payload changed while stalled");

    // Back-pressure only passes upstream when the sink stalls.
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall)
        else $error("input stalled without output stall");

    // An empty output stage always leaves room for a new sample.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output stage empty");

    // The clamp keeps humidity within 0 to 100 percent.
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hum_q10 <= HUM_Q10_MAX)
        else $error("humidity above clamp limit");

endmodule

bind temp_humidity_compensation_core thc_checker u_thc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_fine_temp  (o_fine_temp),
    .o_temp_centi (o_temp_centi),
    .o_hum_q10    (o_hum_q10)
);
